>>> rtl/qpr_pkg.sv
// Package for the quaternion product and rotate block.
// Holds the mode codes, the stage control struct and the Hamilton product term tables.
// Depends on nothing.
package qpr_pkg;

  typedef enum logic {
    MODE_PRODUCT = 1'b0,
    MODE_ROTATE  = 1'b1
  } mode_e;

  // Control that travels alongside the data through every pipeline stage.
  typedef struct packed {
    logic  valid;
    mode_e mode;
    logic  sat;
  } stage_ctl_t;

  localparam int unsigned NUM_COMP  = 4;
  localparam int unsigned NUM_TERMS = 16;

  // Term j of output component j/4 is (+/-) a[HAM_A_IDX[j]] * b[HAM_B_IDX[j]].
  localparam logic [1:0] HAM_A_IDX [NUM_TERMS] = '{
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd0, 2'd2, 2'd3, 2'd1,
    2'd0, 2'd3, 2'd1, 2'd2
  };
  localparam logic [1:0] HAM_B_IDX [NUM_TERMS] = '{
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd1, 2'd0, 2'd3, 2'd2,
    2'd2, 2'd0, 2'd1, 2'd3,
    2'd3, 2'd0, 2'd2, 2'd1
  };
  localparam logic HAM_NEG [NUM_TERMS] = '{
    1'b0, 1'b1, 1'b1, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1
  };

endpackage

>>> rtl/qpr_in_if.sv
// Request channel interface of the quaternion product and rotate block.
// Carries valid, ready and the two input quaternions with the mode bit; no dependencies.
interface qpr_in_if #(
  parameter int unsigned W = 16
);
  logic                valid;
  logic                ready;
  logic                mode;
  logic signed [W-1:0] a_w;
  logic signed [W-1:0] a_x;
  logic signed [W-1:0] a_y;
  logic signed [W-1:0] a_z;
  logic signed [W-1:0] b_w;
  logic signed [W-1:0] b_x;
  logic signed [W-1:0] b_y;
  logic signed [W-1:0] b_z;

  modport source (
    output valid, mode, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
    input  ready
  );
  modport sink (
    input  valid, mode, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
    output ready
  );
endinterface

>>> rtl/qpr_out_if.sv
// Result channel interface of the quaternion product and rotate block.
// Carries valid, ready, the result quaternion and the saturation flag; no dependencies.
interface qpr_out_if #(
  parameter int unsigned W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] r_w;
  logic signed [W-1:0] r_x;
  logic signed [W-1:0] r_y;
  logic signed [W-1:0] r_z;
  logic                saturated;

  modport source (
    output valid, r_w, r_x, r_y, r_z, saturated,
    input  ready
  );
  modport sink (
    input  valid, r_w, r_x, r_y, r_z, saturated,
    output ready
  );
endinterface

>>> rtl/qpr_mul.sv
// Multiplier stage: forms and registers the sixteen partial products of a Hamilton product.
// Depends on qpr_pkg.
module qpr_mul #(
  parameter int unsigned W = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  qpr_pkg::stage_ctl_t        ctl_i,
  input  logic signed [W:0]          a_i    [4],
  input  logic signed [W:0]          b_i    [4],
  input  logic signed [W-1:0]        side_i [4],
  output qpr_pkg::stage_ctl_t        ctl_o,
  output logic signed [2*W+1:0]      prod_o [16],
  output logic signed [W-1:0]        side_o [4]
);
  import qpr_pkg::*;

  localparam int unsigned PW = 2 * W + 2;

  stage_ctl_t          ctl_q;
  logic signed [PW-1:0] prod_d [NUM_TERMS];
  logic signed [PW-1:0] prod_q [NUM_TERMS];
  logic signed [W-1:0]  side_q [NUM_COMP];

  always_comb begin
    for (int j = 0; j < NUM_TERMS; j++) begin
      prod_d[j] = a_i[HAM_A_IDX[j]] * b_i[HAM_B_IDX[j]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      side_q <= side_i;
    end
  end

  assign ctl_o  = ctl_q;
  assign prod_o = prod_q;
  assign side_o = side_q;

endmodule

>>> rtl/qpr_sum.sv
// Summing stage: adds the signed partial products, floors by the fraction bits,
// saturates each component and registers the result. Depends on qpr_pkg.
module qpr_sum #(
  parameter int unsigned W = 16,
  parameter int unsigned F = 14
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  qpr_pkg::stage_ctl_t        ctl_i,
  input  logic signed [2*W+1:0]      prod_i [16],
  input  logic signed [W-1:0]        side_i [4],
  input  logic                       byp_i,
  output qpr_pkg::stage_ctl_t        ctl_o,
  output logic signed [W-1:0]        comp_o [4],
  output logic signed [W-1:0]        side_o [4]
);
  import qpr_pkg::*;

  localparam int unsigned SW = 2 * W + 3;
  localparam logic signed [SW-1:0] CLIP_HI = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] CLIP_LO = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

  stage_ctl_t          ctl_d;
  stage_ctl_t          ctl_q;
  logic signed [W-1:0] comp_d [NUM_COMP];
  logic signed [W-1:0] comp_q [NUM_COMP];
  logic signed [W-1:0] side_q [NUM_COMP];
  logic signed [SW-1:0] sum   [NUM_COMP];
  logic signed [SW-1:0] shf   [NUM_COMP];
  logic [NUM_COMP-1:0]  clip;

  always_comb begin
    for (int k = 0; k < NUM_COMP; k++) begin
      sum[k] = '0;
      for (int j = 0; j < 4; j++) begin
        if (HAM_NEG[4*k+j]) begin
          sum[k] = sum[k] - SW'(prod_i[4*k+j]);
        end else begin
          sum[k] = sum[k] + SW'(prod_i[4*k+j]);
        end
      end
      shf[k] = sum[k] >>> F;
      if (shf[k] > CLIP_HI) begin
        clip[k]   = 1'b1;
        comp_d[k] = CLIP_HI[W-1:0];
      end else if (shf[k] < CLIP_LO) begin
        clip[k]   = 1'b1;
        comp_d[k] = CLIP_LO[W-1:0];
      end else begin
        clip[k]   = 1'b0;
        comp_d[k] = shf[k][W-1:0];
      end
      // When bypassed, the component computed earlier passes through unchanged.
      if (byp_i) begin
        comp_d[k] = side_i[k];
      end
    end
    ctl_d     = ctl_i;
    ctl_d.sat = ctl_i.sat | (!byp_i & (|clip));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      comp_q <= comp_d;
      side_q <= side_i;
    end
  end

  assign ctl_o  = ctl_q;
  assign comp_o = comp_q;
  assign side_o = side_q;

endmodule

>>> rtl/quaternion_product_and_rotate_top.sv
// Quaternion product and vector rotation: a four-stage pipeline that accepts one request
// in every cycle unless it is full behind a stalled result, and registers its result. Each
// request carries quaternions a and b in signed fixed point and a mode bit. In product
// mode the result is the Hamilton product a*b. In rotate mode the block forms
// t = a*(0, b.xyz) and then t*conj(a); the result's x, y and z hold the rotated vector and
// w holds a scalar that is normally discarded. Every product is floored by FRACTION_BITS
// and saturated to COMPONENT_WIDTH bits; the saturated flag is set if any component of
// the item, including those of the intermediate t, was clipped. The rate is one request
// per cycle, set by the four register stages (multiply, sum, multiply, sum) that each take
// a new item whenever the stage after them moves on. A request passes through the stages
// in that order before its result is valid; a stalled result stage holds its data and
// lets earlier stages fill behind it.
// Depends on qpr_pkg, qpr_in_if, qpr_out_if, qpr_mul and qpr_sum.
module quaternion_product_and_rotate_top #(
  parameter int unsigned COMPONENT_WIDTH = 16,
  parameter int unsigned FRACTION_BITS   = 14
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  qpr_in_if.sink   req_i,
  qpr_out_if.source rsp_o
);
  import qpr_pkg::*;

  localparam int unsigned W  = COMPONENT_WIDTH;
  localparam int unsigned PW = 2 * W + 2;

  // Stage control and handshake. A stage loads when it is empty or the stage after it
  // moves on in the same cycle; the chain ends at the result channel's ready.
  stage_ctl_t ctl0, ctl1, ctl2, ctl3, ctl4;
  logic       en1, en2, en3, en4;

  assign en4 = !ctl4.valid || rsp_o.ready;
  assign en3 = !ctl3.valid || en4;
  assign en2 = !ctl2.valid || en3;
  assign en1 = !ctl1.valid || en2;

  assign req_i.ready = en1;

  always_comb begin
    ctl0.valid = req_i.valid;
    ctl0.mode  = mode_e'(req_i.mode);
    ctl0.sat   = 1'b0;
  end

  // First product operands. In rotate mode the scalar of b is forced to zero, so the
  // first product is a times the pure quaternion (0, b.xyz).
  logic signed [W:0]   op1_a [NUM_COMP];
  logic signed [W:0]   op1_b [NUM_COMP];
  logic signed [W-1:0] a_in  [NUM_COMP];

  always_comb begin
    a_in[0]  = req_i.a_w;
    a_in[1]  = req_i.a_x;
    a_in[2]  = req_i.a_y;
    a_in[3]  = req_i.a_z;
    op1_a[0] = {req_i.a_w[W-1], req_i.a_w};
    op1_a[1] = {req_i.a_x[W-1], req_i.a_x};
    op1_a[2] = {req_i.a_y[W-1], req_i.a_y};
    op1_a[3] = {req_i.a_z[W-1], req_i.a_z};
    op1_b[0] = (ctl0.mode == MODE_ROTATE) ? '0 : {req_i.b_w[W-1], req_i.b_w};
    op1_b[1] = {req_i.b_x[W-1], req_i.b_x};
    op1_b[2] = {req_i.b_y[W-1], req_i.b_y};
    op1_b[3] = {req_i.b_z[W-1], req_i.b_z};
  end

  // Stage 1: partial products of a*b; a travels along for the conjugate.
  logic signed [PW-1:0] prod1  [NUM_TERMS];
  logic signed [W-1:0]  a_s1   [NUM_COMP];

  qpr_mul #(.W(W)) u_mul1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en1),
    .ctl_i  (ctl0),
    .a_i    (op1_a),
    .b_i    (op1_b),
    .side_i (a_in),
    .ctl_o  (ctl1),
    .prod_o (prod1),
    .side_o (a_s1)
  );

  // Stage 2: t, floored and saturated; its clips already count toward the flag.
  logic signed [W-1:0] t_s2 [NUM_COMP];
  logic signed [W-1:0] a_s2 [NUM_COMP];

  qpr_sum #(.W(W), .F(FRACTION_BITS)) u_sum1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en2),
    .ctl_i  (ctl1),
    .prod_i (prod1),
    .side_i (a_s1),
    .byp_i  (1'b0),
    .ctl_o  (ctl2),
    .comp_o (t_s2),
    .side_o (a_s2)
  );

  // Second product operands: t and conj(a). The conjugate is negated with one extra bit,
  // so the most negative component becomes its exact positive magnitude.
  logic signed [W:0] op2_a [NUM_COMP];
  logic signed [W:0] op2_b [NUM_COMP];

  always_comb begin
    for (int k = 0; k < NUM_COMP; k++) begin
      op2_a[k] = {t_s2[k][W-1], t_s2[k]};
    end
    op2_b[0] = {a_s2[0][W-1], a_s2[0]};
    for (int k = 1; k < NUM_COMP; k++) begin
      op2_b[k] = -{a_s2[k][W-1], a_s2[k]};
    end
  end

  // Stage 3: partial products of t*conj(a); t travels along for product mode.
  logic signed [PW-1:0] prod3 [NUM_TERMS];
  logic signed [W-1:0]  t_s3  [NUM_COMP];

  qpr_mul #(.W(W)) u_mul2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en3),
    .ctl_i  (ctl2),
    .a_i    (op2_a),
    .b_i    (op2_b),
    .side_i (t_s2),
    .ctl_o  (ctl3),
    .prod_o (prod3),
    .side_o (t_s3)
  );

  // Stage 4: final sum. In product mode the result is t itself, and the unused second
  // product cannot set the flag.
  logic signed [W-1:0] r_s4    [NUM_COMP];
  logic signed [W-1:0] side_s4 [NUM_COMP];

  qpr_sum #(.W(W), .F(FRACTION_BITS)) u_sum2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en4),
    .ctl_i  (ctl3),
    .prod_i (prod3),
    .side_i (t_s3),
    .byp_i  (ctl3.mode == MODE_PRODUCT),
    .ctl_o  (ctl4),
    .comp_o (r_s4),
    .side_o (side_s4)
  );

  assign rsp_o.valid     = ctl4.valid;
  assign rsp_o.r_w       = r_s4[0];
  assign rsp_o.r_x       = r_s4[1];
  assign rsp_o.r_y       = r_s4[2];
  assign rsp_o.r_z       = r_s4[3];
  assign rsp_o.saturated = ctl4.sat;

endmodule

>>> dv/quaternion_product_and_rotate_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the quaternion product and rotate pipeline.
// It predicts each result at request time and checks results in order.
// Depends on qpr_pkg, qpr_in_if, qpr_out_if and quaternion_product_and_rotate_top.
module quaternion_product_and_rotate_top_test;
  import qpr_pkg::*;

  localparam int unsigned COMP_W    = 16;
  localparam int unsigned FRAC_BITS = 14;
  localparam longint      COMP_MAX  = (64'sd1 <<< (COMP_W - 1)) - 1;
  localparam longint      COMP_MIN  = -COMP_MAX - 1;

  // The longest legal stretch without any handshake is the long receiver hold-off
  // plus one sender gap. This limit is many times that.
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned IDLE_LIMIT     = 5000;
  localparam int unsigned DRAIN_CYCLES   = 8;

  // One request as the testbench sees it. The fields match the request channel.
  typedef struct packed {
    mode_e              mode;
    logic signed [15:0] a_w;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] b_w;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
  } quat_req_t;

  // One result: the four components and the saturation flag.
  typedef struct packed {
    logic [15:0] w;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        sat;
  } quat_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  qpr_in_if  #(.W(COMP_W)) req_if ();
  qpr_out_if #(.W(COMP_W)) rsp_if ();

  quaternion_product_and_rotate_top #(
    .COMPONENT_WIDTH(COMP_W),
    .FRACTION_BITS  (FRAC_BITS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Results predicted at the moment each request is accepted, oldest first.
  quat_rsp_t   quat_results_q[$];
  int unsigned fail_count   = 0;
  int unsigned idle_cycles  = 0;
  // When idle_on is low, neither side inserts gaps. holdoff_req asks the
  // receiver for one long stretch with ready low.
  bit          idle_on      = 1'b1;
  bit          holdoff_req  = 1'b0;

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Floors a full-precision sum by the fraction width and clips it to the
  // component range. Any clip is recorded in sat.
  function automatic longint floor_and_clip(input longint sum, inout logic sat);
    longint shifted;
    shifted = sum >>> FRAC_BITS;
    if (shifted > COMP_MAX) begin
      sat = 1'b1;
      return COMP_MAX;
    end
    if (shifted < COMP_MIN) begin
      sat = 1'b1;
      return COMP_MIN;
    end
    return shifted;
  endfunction

  // Hamilton product p*q. The four partial products of each component are
  // summed exactly before the floor and the clip.
  function automatic void hamilton_mult(
    input  longint pw, px, py, pz,
    input  longint qw, qx, qy, qz,
    output longint ow, ox, oy, oz,
    inout  logic   sat
  );
    ow = floor_and_clip(pw * qw - px * qx - py * qy - pz * qz, sat);
    ox = floor_and_clip(pw * qx + px * qw + py * qz - pz * qy, sat);
    oy = floor_and_clip(pw * qy + py * qw + pz * qx - px * qz, sat);
    oz = floor_and_clip(pw * qz + pz * qw + px * qy - py * qx, sat);
  endfunction

  // Expected result of one request. In rotate mode the intermediate t is
  // clipped to the component range, while the conjugate of a keeps one extra
  // bit, so that negating the most negative component does not clip.
  function automatic quat_rsp_t compute_quat_result(input quat_req_t req);
    longint    aw, ax, ay, az, bw, bx, by, bz;
    longint    tw, tx, ty, tz, rw, rx, ry, rz;
    logic      sat;
    quat_rsp_t rsp;
    aw  = $signed(req.a_w);
    ax  = $signed(req.a_x);
    ay  = $signed(req.a_y);
    az  = $signed(req.a_z);
    bw  = $signed(req.b_w);
    bx  = $signed(req.b_x);
    by  = $signed(req.b_y);
    bz  = $signed(req.b_z);
    sat = 1'b0;
    if (req.mode == MODE_ROTATE) begin
      hamilton_mult(aw, ax, ay, az, 0, bx, by, bz, tw, tx, ty, tz, sat);
      hamilton_mult(tw, tx, ty, tz, aw, -ax, -ay, -az, rw, rx, ry, rz, sat);
    end else begin
      hamilton_mult(aw, ax, ay, az, bw, bx, by, bz, rw, rx, ry, rz, sat);
    end
    rsp.w   = rw[15:0];
    rsp.x   = rx[15:0];
    rsp.y   = ry[15:0];
    rsp.z   = rz[15:0];
    rsp.sat = sat;
    return rsp;
  endfunction

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random component. Mixes the extremes, zero, values around unit length and
  // fully random words, so that every bit of every field toggles.
  function automatic logic signed [15:0] rand_component(input int unsigned flavor);
    case (flavor)
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      1: return 16'($signed($urandom_range(0, 23170)) - 11585);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic quat_req_t rand_request();
    quat_req_t   req;
    int unsigned flavor;
    int unsigned roll;
    roll = $urandom_range(0, 9);
    // Four in ten draw moderate components, which is how the block is used; the rest
    // probe saturation and the corners.
    flavor  = (roll < 4) ? 1 : ((roll < 7) ? 2 : 0);
    req.mode = mode_e'($urandom_range(0, 1));
    req.a_w  = rand_component(flavor);
    req.a_x  = rand_component(flavor);
    req.a_y  = rand_component(flavor);
    req.a_z  = rand_component(flavor);
    req.b_w  = rand_component(flavor);
    req.b_x  = rand_component(flavor);
    req.b_y  = rand_component(flavor);
    req.b_z  = rand_component(flavor);
    return req;
  endfunction

  function automatic quat_req_t make_request(
    input mode_e m,
    input logic signed [15:0] aw, ax, ay, az, bw, bx, by, bz
  );
    quat_req_t req;
    req.mode = m;
    req.a_w  = aw;
    req.a_x  = ax;
    req.a_y  = ay;
    req.a_z  = az;
    req.b_w  = bw;
    req.b_x  = bx;
    req.b_y  = by;
    req.b_z  = bz;
    return req;
  endfunction

  // Offers one request and holds it until the block takes it. The expected
  // result is queued at the edge that accepts the request. The task is called
  // at a rising edge and returns at one, so valid is never lowered and raised
  // again within one time step.
  task automatic send_request(input quat_req_t req, input int unsigned gap);
    req_if.valid <= 1'b1;
    req_if.mode  <= req.mode;
    req_if.a_w   <= req.a_w;
    req_if.a_x   <= req.a_x;
    req_if.a_y   <= req.a_y;
    req_if.a_z   <= req.a_z;
    req_if.b_w   <= req.b_w;
    req_if.b_x   <= req.b_x;
    req_if.b_y   <= req.b_y;
    req_if.b_z   <= req.b_z;
    do @(posedge clk); while (!req_if.ready);
    quat_results_q.push_back(compute_quat_result(req));
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering requests and waits until every expected result has come,
  // then lets the pipeline settle before returning.
  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    while (quat_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Corners of the fields and the special cases: floor of negative sums,
  // saturation in both modes, the conjugate of the most negative component,
  // clipping of the intermediate t, an unnormalized a and the ignored b_w.
  task automatic test_directed_corners();
    quat_req_t reqs[$];
    reqs.push_back(make_request(MODE_PRODUCT, 0, 0, 0, 0, 0, 0, 0, 0));
    reqs.push_back(make_request(MODE_PRODUCT, 16384, 0, 0, 0, 16384, 0, 0, 0));
    reqs.push_back(make_request(MODE_PRODUCT, 0, 16384, 0, 0, 0, 0, 16384, 0));
    reqs.push_back(make_request(MODE_PRODUCT, -1, 0, 0, 0, 1, 0, 0, 0));
    reqs.push_back(make_request(MODE_PRODUCT, -1, -1, 1, 1, 1, 1, -1, 1));
    reqs.push_back(make_request(MODE_PRODUCT, 32767, 32767, 32767, 32767,
                                32767, 32767, 32767, 32767));
    reqs.push_back(make_request(MODE_PRODUCT, -32768, -32768, -32768, -32768,
                                -32768, -32768, -32768, -32768));
    reqs.push_back(make_request(MODE_PRODUCT, 32767, -32768, 32767, -32768,
                                -32768, 32767, -32768, 32767));
    reqs.push_back(make_request(MODE_PRODUCT, -32768, 0, 0, 0, -32768, 0, 0, 0));
    reqs.push_back(make_request(MODE_PRODUCT, 11585, 0, 0, 11585, -11585, 0, 11585, 0));
    reqs.push_back(make_request(MODE_ROTATE, 0, 0, 0, 0, -32768, 0, 0, 0));
    reqs.push_back(make_request(MODE_ROTATE, 16384, 0, 0, 0, 12345, 1000, -2000, 3000));
    reqs.push_back(make_request(MODE_ROTATE, 11585, 0, 0, 11585, 0, 16384, 0, 0));
    reqs.push_back(make_request(MODE_ROTATE, 8192, 8192, 8192, 8192, 32767, 0, 16384, 0));
    reqs.push_back(make_request(MODE_ROTATE, 0, -32768, -32768, -32768,
                                0, 32767, 32767, 32767));
    reqs.push_back(make_request(MODE_ROTATE, 0, -32768, 0, 0, 0, 0, 1, 0));
    reqs.push_back(make_request(MODE_ROTATE, 32767, 32767, 32767, 32767,
                                32767, 32767, 32767, 32767));
    reqs.push_back(make_request(MODE_ROTATE, -32768, -32768, -32768, -32768,
                                -32768, -32768, -32768, -32768));
    reqs.push_back(make_request(MODE_ROTATE, 32767, 0, 0, 0, 0, 16384, -16384, 1));
    reqs.push_back(make_request(MODE_ROTATE, 16384, 0, 0, 0, 32767, -32768, 32767, -1));
    reqs.push_back(make_request(MODE_ROTATE, -1, 1, -1, 1, -1, -1, 1, -1));
    foreach (reqs[i]) send_request(reqs[i], pick_gap());
    wait_for_results();
  endtask

  // The bulk of the run: random requests with random gaps on both sides.
  task automatic test_random_requests(input int unsigned count);
    repeat (count) send_request(rand_request(), pick_gap());
    wait_for_results();
  endtask

  // The receiver holds ready low for a long stretch while requests keep
  // coming, so that the pipeline fills up and stalls the request side.
  task automatic test_result_backpressure();
    holdoff_req = 1'b1;
    repeat (40) send_request(rand_request(), 0);
    wait_for_results();
  endtask

  // Short bursts, each followed by a pause until every result has arrived.
  task automatic test_burst_and_drain();
    repeat (5) begin
      repeat (10) send_request(rand_request(), pick_gap());
      wait_for_results();
    end
  endtask

  // Back-to-back traffic with no gaps on either side, one request per cycle.
  task automatic test_full_rate();
    idle_on = 1'b0;
    repeat (100) send_request(rand_request(), 0);
    wait_for_results();
    idle_on = 1'b1;
  endtask

  // Receiver: ready goes low for random stretches, or for one long hold-off
  // when a test asks for it. At most one assignment to ready per edge.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES - 1) @(posedge clk);
        holdoff_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(8, 40) : $urandom_range(0, 2))
          @(posedge clk);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Result checker: every accepted result is compared with the oldest
  // prediction. Inputs and outputs are sampled at the edge, before any
  // nonblocking update of that edge takes effect.
  always @(posedge clk) begin
    quat_rsp_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (quat_results_q.size() == 0) begin
        $error("result with no request waiting: r_w %0d r_x %0d r_y %0d r_z %0d sat %0b",
               rsp_if.r_w, rsp_if.r_x, rsp_if.r_y, rsp_if.r_z, rsp_if.saturated);
        fail_count++;
      end else begin
        want = quat_results_q.pop_front();
        if (rsp_if.r_w !== want.w) begin
          $error("r_w mismatch: expected %0d, actual %0d", $signed(want.w), rsp_if.r_w);
          fail_count++;
        end
        if (rsp_if.r_x !== want.x) begin
          $error("r_x mismatch: expected %0d, actual %0d", $signed(want.x), rsp_if.r_x);
          fail_count++;
        end
        if (rsp_if.r_y !== want.y) begin
          $error("r_y mismatch: expected %0d, actual %0d", $signed(want.y), rsp_if.r_y);
          fail_count++;
        end
        if (rsp_if.r_z !== want.z) begin
          $error("r_z mismatch: expected %0d, actual %0d", $signed(want.z), rsp_if.r_z);
          fail_count++;
        end
        if (rsp_if.saturated !== want.sat) begin
          $error("saturated mismatch: expected %0b, actual %0b", want.sat, rsp_if.saturated);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $error("no request or result moved for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Test sequence. Reset is applied once; the block keeps no state between
  // requests and has no configuration, so every test runs straight from reset.
  initial begin
    rst_n        <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.mode  <= MODE_PRODUCT;
    req_if.a_w   <= '0;
    req_if.a_x   <= '0;
    req_if.a_y   <= '0;
    req_if.a_z   <= '0;
    req_if.b_w   <= '0;
    req_if.b_x   <= '0;
    req_if.b_y   <= '0;
    req_if.b_z   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_directed_corners();
    test_random_requests(550);
    test_result_backpressure();
    test_burst_and_drain();
    test_full_rate();
    test_random_requests(50);

    if (quat_results_q.size() != 0) begin
      $error("%0d expected results never arrived", quat_results_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/qpr_pkg.sv
rtl/qpr_in_if.sv
rtl/qpr_out_if.sv
rtl/qpr_mul.sv
rtl/qpr_sum.sv
rtl/quaternion_product_and_rotate_top.sv
dv/quaternion_product_and_rotate_top_test.sv
